// ----- hdl/rrht_pkg.sv -----
package rrht_pkg;

  // Fixed widths of the request and response fields.
  localparam int SLOT_ID_W    = 6;
  localparam int VALUE_PORT_W = 64;
  localparam int STATE_W      = 2;
  localparam int COUNT_PORT_W = 7;

  // Request kinds.
  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_BIND    = 2'd2,
    KIND_LOOKUP  = 2'd3
  } kind_t;

  // Reported slot states.
  localparam logic [STATE_W-1:0] SLOT_FREE     = 2'd0;
  localparam logic [STATE_W-1:0] SLOT_RESERVED = 2'd1;
  localparam logic [STATE_W-1:0] SLOT_BOUND    = 2'd2;

  // Response status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

// ----- hdl/rrht_req_if.sv -----
interface rrht_req_if;

  logic                               valid;
  logic                               ready;
  logic [1:0]                         kind;
  logic [rrht_pkg::SLOT_ID_W-1:0]     slot_id;
  logic [rrht_pkg::VALUE_PORT_W-1:0]  bind_value;

  modport source (output valid, kind, slot_id, bind_value, input ready);
  modport sink   (input valid, kind, slot_id, bind_value, output ready);

endinterface

// ----- hdl/rrht_rsp_if.sv -----
interface rrht_rsp_if;

  logic                               valid;
  logic                               ready;
  logic [rrht_pkg::SLOT_ID_W-1:0]     result_slot;
  logic [rrht_pkg::VALUE_PORT_W-1:0]  read_value;
  logic [rrht_pkg::STATE_W-1:0]       slot_state;
  logic                               status;
  logic [rrht_pkg::COUNT_PORT_W-1:0]  used_count;

  modport source (output valid, result_slot, read_value, slot_state, status, used_count,
                  input ready);
  modport sink   (input valid, result_slot, read_value, slot_state, status, used_count,
                  output ready);

endinterface

// ----- hdl/rrht_ram.sv -----
// Simple dual-port RAM: one write port, one read port with registered data.
module rrht_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/round_robin_handle_table_core.sv -----
// Handle table with a round-robin slot allocator. Each slot lives in one word of a
// single on-chip RAM that holds a reserved flag and the bound value; the used count and
// the search pointer sit in registers. Release, bind, lookup and an allocate made while
// the used count is at the table size read the slot from the accepted request beat, then
// write it back and register the response once the output register is free. An allocate
// reads the RAM one slot per cycle starting one past the last slot handed out, stepping
// over occupied slots until a free one turns up or every slot is checked and it reports
// full. One request is in flight at a time; a finished response waits in the output
// register while the next request is accepted. After reset the RAM is cleared one word
// per cycle, so no request is accepted until every word has been cleared.
module round_robin_handle_table_core #(
  parameter int TABLE_SIZE  = 64,
  parameter int VALUE_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  rrht_req_if.sink    req,
  rrht_rsp_if.source  rsp
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam int MW = VALUE_WIDTH + 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SIZE - 1);
  localparam logic [CW-1:0] TABLE_CNT = CW'(TABLE_SIZE);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_SCAN  = 4'b1000
  } state_t;

  state_t                 state, state_next;
  logic [AW-1:0]          clr_addr;
  logic [AW-1:0]          ptr, ptr_next;
  logic [CW-1:0]          cnt, cnt_next;
  logic [CW-1:0]          scan_cnt, scan_cnt_next;
  logic [AW-1:0]          rd_addr;

  // Latched request.
  rrht_pkg::kind_t                 req_kind;
  logic [rrht_pkg::SLOT_ID_W-1:0]  req_id;
  logic [VALUE_WIDTH-1:0]          req_val;

  // Output register.
  logic                                out_valid;
  logic [rrht_pkg::SLOT_ID_W-1:0]      out_slot;
  logic [rrht_pkg::VALUE_PORT_W-1:0]   out_value;
  logic [rrht_pkg::STATE_W-1:0]        out_state;
  logic                                out_status;
  logic [rrht_pkg::COUNT_PORT_W-1:0]   out_count;

  // Response being formed this cycle.
  logic                                out_load;
  logic [rrht_pkg::SLOT_ID_W-1:0]      o_slot;
  logic [rrht_pkg::VALUE_PORT_W-1:0]   o_value;
  logic [rrht_pkg::STATE_W-1:0]        o_state;
  logic                                o_status;

  // RAM ports.
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [MW-1:0]   mem_wdata;
  logic [AW-1:0]   mem_raddr;
  logic [MW-1:0]   mem_rdata;

  logic                    req_fire;
  rrht_pkg::kind_t         in_kind;
  logic                    out_free;
  logic                    req_in_range;
  logic [VALUE_WIDTH-1:0]  rd_value;
  logic                    rd_reserved;
  logic                    rd_occupied;
  logic                    scan_last;

  // Next slot in round-robin order.
  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] a);
    return (a == LAST_SLOT) ? '0 : a + AW'(1);
  endfunction

  rrht_ram #(
    .WIDTH (MW),
    .DEPTH (TABLE_SIZE)
  ) u_slot_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Handshake and decoded read data.
  assign req.ready    = (state == S_IDLE);
  assign req_fire     = req.valid && req.ready;
  assign in_kind      = rrht_pkg::kind_t'(req.kind);
  assign out_free     = !out_valid || rsp.ready;
  assign req_in_range = (32'(req_id) < TABLE_SIZE);
  assign rd_value     = mem_rdata[VALUE_WIDTH-1:0];
  assign rd_reserved  = mem_rdata[VALUE_WIDTH];
  assign rd_occupied  = rd_reserved || (rd_value != '0);
  assign scan_last    = (scan_cnt == TABLE_CNT - CW'(1));

  // Read address. The scan advances one slot a cycle and holds on the slot where it
  // stops, so the data stays valid while the response waits for the output register.
  always_comb begin
    priority case (1'b1)
      (state == S_IDLE): begin
        mem_raddr = (in_kind == rrht_pkg::KIND_ALLOC) ? next_slot(ptr) : AW'(req.slot_id);
      end
      (state == S_SCAN): begin
        mem_raddr = (!rd_occupied || scan_last) ? rd_addr : next_slot(rd_addr);
      end
      default: begin
        mem_raddr = rd_addr;
      end
    endcase
  end

  // Control, write-back and response forming.
  always_comb begin
    state_next    = state;
    ptr_next      = ptr;
    cnt_next      = cnt;
    scan_cnt_next = scan_cnt;
    mem_we        = 1'b0;
    mem_waddr     = rd_addr;
    mem_wdata     = '0;
    out_load      = 1'b0;
    o_slot        = req_id;
    o_value       = '0;
    o_state       = rrht_pkg::SLOT_FREE;
    o_status      = rrht_pkg::STATUS_OK;

    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        if (clr_addr == LAST_SLOT) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        scan_cnt_next = '0;
        if (req_fire) begin
          if (in_kind == rrht_pkg::KIND_ALLOC && cnt < TABLE_CNT) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          unique case (req_kind)
            rrht_pkg::KIND_ALLOC: begin
              // Only a full table reaches this point with an allocate.
              o_slot   = '0;
              o_status = rrht_pkg::STATUS_FULL;
            end
            rrht_pkg::KIND_RELEASE: begin
              if (req_in_range) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(req_id);
                if (cnt != '0) begin
                  cnt_next = cnt - CW'(1);
                end
              end
            end
            rrht_pkg::KIND_BIND: begin
              if (req_in_range) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(req_id);
                mem_wdata = {1'b0, req_val};
                o_state   = (req_val != '0) ? rrht_pkg::SLOT_BOUND : rrht_pkg::SLOT_FREE;
              end
            end
            rrht_pkg::KIND_LOOKUP: begin
              if (req_in_range) begin
                o_value = rrht_pkg::VALUE_PORT_W'(rd_value);
                if (rd_value != '0) begin
                  o_state = rrht_pkg::SLOT_BOUND;
                end else if (rd_reserved) begin
                  o_state = rrht_pkg::SLOT_RESERVED;
                end
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        if (!rd_occupied) begin
          // Free slot found: reserve it and move the pointer there.
          if (out_free) begin
            mem_we     = 1'b1;
            mem_waddr  = rd_addr;
            mem_wdata  = {1'b1, {VALUE_WIDTH{1'b0}}};
            ptr_next   = rd_addr;
            cnt_next   = cnt + CW'(1);
            out_load   = 1'b1;
            o_slot     = rrht_pkg::SLOT_ID_W'(rd_addr);
            o_state    = rrht_pkg::SLOT_RESERVED;
            state_next = S_IDLE;
          end
        end else if (scan_last) begin
          // Every slot checked and none free.
          if (out_free) begin
            out_load   = 1'b1;
            o_slot     = '0;
            o_status   = rrht_pkg::STATUS_FULL;
            state_next = S_IDLE;
          end
        end else begin
          scan_cnt_next = scan_cnt + CW'(1);
        end
      end

      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      ptr      <= '0;
      cnt      <= '0;
      scan_cnt <= '0;
    end else begin
      state    <= state_next;
      ptr      <= ptr_next;
      cnt      <= cnt_next;
      scan_cnt <= scan_cnt_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // Read address tracking and request capture.
  always_ff @(posedge clk) begin
    rd_addr <= mem_raddr;
    if (req_fire) begin
      req_kind <= in_kind;
      req_id   <= req.slot_id;
      req_val  <= req.bind_value[VALUE_WIDTH-1:0];
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_slot   <= o_slot;
      out_value  <= o_value;
      out_state  <= o_state;
      out_status <= o_status;
      out_count  <= rrht_pkg::COUNT_PORT_W'(cnt_next);
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.result_slot = out_slot;
  assign rsp.read_value  = out_value;
  assign rsp.slot_state  = out_state;
  assign rsp.status      = out_status;
  assign rsp.used_count  = out_count;

  // The used count never exceeds the table size.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= TABLE_CNT)
    else $error("used count above table size");

  // A held response beat is never overwritten by a new one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |-> !out_load)
    else $error("response overwritten while stalled");

  // The scan reserves only a slot whose word read back as free.
  a_alloc_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && mem_we) |-> !rd_occupied)
    else $error("allocate reserved an occupied slot");

  // After a reservation the search pointer rests on the reserved slot.
  a_ptr_follow: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && mem_we) |=> (ptr == $past(rd_addr)))
    else $error("search pointer did not follow allocation");

endmodule

// ----- tb/sv/tb_round_robin_handle_table_core.sv -----
`timescale 1ns / 1ps

module tb_round_robin_handle_table_core;

  localparam int TABLE_SLOTS = 64;
  localparam int CLK_HALF_NS = 10;

  typedef struct packed {
    rrht_pkg::kind_t                    kind;
    logic [rrht_pkg::SLOT_ID_W-1:0]     slot_id;
    logic [rrht_pkg::VALUE_PORT_W-1:0]  bind_value;
  } handle_request_t;

  typedef struct packed {
    logic [rrht_pkg::SLOT_ID_W-1:0]     slot;
    logic [rrht_pkg::VALUE_PORT_W-1:0]  value;
    logic [rrht_pkg::STATE_W-1:0]       state;
    logic                               status;
    logic [rrht_pkg::COUNT_PORT_W-1:0]  used;
  } handle_response_t;

  logic clk;
  logic rst;

  rrht_req_if req_ch ();
  rrht_rsp_if rsp_ch ();

  round_robin_handle_table_core #(
    .TABLE_SIZE  (TABLE_SLOTS),
    .VALUE_WIDTH (rrht_pkg::VALUE_PORT_W)
  ) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the handle table.
  logic [rrht_pkg::VALUE_PORT_W-1:0]  shadow_value [TABLE_SLOTS];
  bit                                 shadow_reserved [TABLE_SLOTS];
  logic [rrht_pkg::COUNT_PORT_W-1:0]  shadow_used;
  logic [rrht_pkg::SLOT_ID_W-1:0]     shadow_last_given;

  handle_request_t  pending_requests [$];
  handle_response_t awaited_responses [$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatch_count;
  int responses_checked;
  int requests_accepted;
  int full_responses;
  int allocates_accepted;

  // Clock, reset and known values on every input from time zero.
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.kind = rrht_pkg::KIND_LOOKUP;
    req_ch.slot_id = '0;
    req_ch.bind_value = '0;
    rsp_ch.ready = 1'b0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      shadow_value[i] = '0;
      shadow_reserved[i] = 1'b0;
    end
    shadow_used = '0;
    shadow_last_given = '0;
    fork
      forever #CLK_HALF_NS clk = ~clk;
      begin
        repeat (10) @(posedge clk);
        rst <= 1'b0;
      end
    join
  end

  // Works out the response to one request and updates the shadow table.
  function automatic handle_response_t predict_response(handle_request_t r);
    handle_response_t result;
    logic [rrht_pkg::SLOT_ID_W-1:0] probe;
    bit found;
    int i;
    result.slot = r.slot_id;
    result.value = '0;
    result.state = rrht_pkg::SLOT_FREE;
    result.status = rrht_pkg::STATUS_OK;
    found = 1'b0;
    probe = shadow_last_given;
    case (r.kind)
      rrht_pkg::KIND_ALLOC: begin
        // Step one past the last slot handed out until a free one turns up.
        if (shadow_used < TABLE_SLOTS) begin
          for (i = 0; i < TABLE_SLOTS; i++) begin
            if (!found) begin
              probe = probe + rrht_pkg::SLOT_ID_W'(1);
              if (!shadow_reserved[probe] && shadow_value[probe] == '0) found = 1'b1;
            end
          end
        end
        if (found) begin
          shadow_last_given = probe;
          shadow_reserved[probe] = 1'b1;
          shadow_value[probe] = '0;
          shadow_used = shadow_used + rrht_pkg::COUNT_PORT_W'(1);
          result.slot = probe;
          result.state = rrht_pkg::SLOT_RESERVED;
        end else begin
          result.slot = '0;
          result.status = rrht_pkg::STATUS_FULL;
        end
      end
      rrht_pkg::KIND_RELEASE: begin
        if (shadow_used > 0) shadow_used = shadow_used - rrht_pkg::COUNT_PORT_W'(1);
        shadow_value[r.slot_id] = '0;
        shadow_reserved[r.slot_id] = 1'b0;
      end
      rrht_pkg::KIND_BIND: begin
        // Binding zero leaves the slot free; the used count is not touched.
        shadow_value[r.slot_id] = r.bind_value;
        shadow_reserved[r.slot_id] = 1'b0;
        result.state = (r.bind_value != '0) ? rrht_pkg::SLOT_BOUND : rrht_pkg::SLOT_FREE;
      end
      default: begin
        result.value = shadow_value[r.slot_id];
        if (shadow_value[r.slot_id] != '0) result.state = rrht_pkg::SLOT_BOUND;
        else if (shadow_reserved[r.slot_id]) result.state = rrht_pkg::SLOT_RESERVED;
      end
    endcase
    result.used = shadow_used;
    return result;
  endfunction

  function automatic logic [rrht_pkg::VALUE_PORT_W-1:0] random_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 15) return '1;
    if (pick < 22) return 64'd1 << $urandom_range(rrht_pkg::VALUE_PORT_W - 1);
    return {$urandom, $urandom};
  endfunction

  // Fill-leaning traffic mostly allocates; drain-leaning traffic mostly releases.
  function automatic handle_request_t random_request(bit fill_leaning);
    handle_request_t r;
    int pick;
    pick = $urandom_range(99);
    r.slot_id = rrht_pkg::SLOT_ID_W'($urandom_range(TABLE_SLOTS - 1));
    r.bind_value = random_value();
    if (fill_leaning) begin
      if (pick < 60) r.kind = rrht_pkg::KIND_ALLOC;
      else if (pick < 75) r.kind = rrht_pkg::KIND_BIND;
      else if (pick < 90) r.kind = rrht_pkg::KIND_LOOKUP;
      else r.kind = rrht_pkg::KIND_RELEASE;
    end else begin
      if (pick < 50) r.kind = rrht_pkg::KIND_RELEASE;
      else if (pick < 65) r.kind = rrht_pkg::KIND_ALLOC;
      else if (pick < 80) r.kind = rrht_pkg::KIND_BIND;
      else r.kind = rrht_pkg::KIND_LOOKUP;
    end
    // Allocates carry random slot and value bits that the block must ignore.
    return r;
  endfunction

  task automatic queue_request(rrht_pkg::kind_t kind, int slot,
                               logic [rrht_pkg::VALUE_PORT_W-1:0] value);
    handle_request_t r;
    r.kind = kind;
    r.slot_id = slot[rrht_pkg::SLOT_ID_W-1:0];
    r.bind_value = value;
    pending_requests.push_back(r);
  endtask

  // Request driver: predicts each accepted beat and offers the next one.
  always @(posedge clk) begin : drive_requests
    handle_request_t next_req;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        next_req.kind = rrht_pkg::kind_t'(req_ch.kind);
        next_req.slot_id = req_ch.slot_id;
        next_req.bind_value = req_ch.bind_value;
        awaited_responses.push_back(predict_response(next_req));
        requests_accepted++;
        if (next_req.kind == rrht_pkg::KIND_ALLOC) allocates_accepted++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_requests.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.kind <= next_req.kind;
          req_ch.slot_id <= next_req.slot_id;
          req_ch.bind_value <= next_req.bind_value;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: compares each beat against the oldest prediction.
  always @(posedge clk) begin : check_responses
    handle_response_t got;
    handle_response_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.slot = rsp_ch.result_slot;
        got.value = rsp_ch.read_value;
        got.state = rsp_ch.slot_state;
        got.status = rsp_ch.status;
        got.used = rsp_ch.used_count;
        if (awaited_responses.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: response beat with no request outstanding: slot=%0d value=%h",
                     got.slot, got.value);
        end else begin
          want = awaited_responses.pop_front();
          responses_checked++;
          if (want.status == rrht_pkg::STATUS_FULL) full_responses++;
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("ERROR: response %0d mismatch", responses_checked);
              $display("  expected slot=%0d value=%h state=%0d status=%0b used=%0d",
                       want.slot, want.value, want.state, want.status, want.used);
              $display("  actual   slot=%0d value=%h state=%0d status=%0b used=%0d",
                       got.slot, got.value, got.state, got.status, got.used);
            end
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stimulus: directed cases, a fill and sweep, then random traffic per idling phase.
  initial begin : stimulus
    bit fill_leaning;
    int chunk_left;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    responses_checked = 0;
    requests_accepted = 0;
    full_responses = 0;
    allocates_accepted = 0;

    // A slot straight out of reset, then the first allocates, which start at slot one.
    queue_request(rrht_pkg::KIND_LOOKUP, 0, '0);
    queue_request(rrht_pkg::KIND_ALLOC, 0, '0);
    queue_request(rrht_pkg::KIND_ALLOC, 63, '1);
    queue_request(rrht_pkg::KIND_LOOKUP, 1, '0);
    // Bind, look up, and free a slot by binding zero.
    queue_request(rrht_pkg::KIND_BIND, 1, '1);
    queue_request(rrht_pkg::KIND_LOOKUP, 1, '0);
    queue_request(rrht_pkg::KIND_BIND, 2, 64'd1);
    queue_request(rrht_pkg::KIND_BIND, 1, '0);
    queue_request(rrht_pkg::KIND_LOOKUP, 1, '1);
    // Release an allocated slot, a free slot, and again with the count at zero.
    queue_request(rrht_pkg::KIND_RELEASE, 2, '0);
    queue_request(rrht_pkg::KIND_RELEASE, 5, '0);
    queue_request(rrht_pkg::KIND_RELEASE, 7, '1);
    // Bind slots that were never allocated; the allocator must step over slot 4.
    queue_request(rrht_pkg::KIND_BIND, 63, 64'h8000_0000_0000_0000);
    queue_request(rrht_pkg::KIND_LOOKUP, 63, '0);
    queue_request(rrht_pkg::KIND_ALLOC, 0, '0);
    queue_request(rrht_pkg::KIND_BIND, 4, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_request(rrht_pkg::KIND_ALLOC, 0, '0);
    queue_request(rrht_pkg::KIND_BIND, 0, 64'h5555_5555_5555_5555);
    queue_request(rrht_pkg::KIND_LOOKUP, 0, '0);
    queue_request(rrht_pkg::KIND_RELEASE, 63, '0);
    queue_request(rrht_pkg::KIND_LOOKUP, 63, '0);

    // Fill the table past its size so allocates wrap and report full, then sweep it clean.
    for (int n = 0; n < 72; n++) queue_request(rrht_pkg::KIND_ALLOC, n, '0);
    queue_request(rrht_pkg::KIND_LOOKUP, 63, '0);
    for (int n = 0; n < TABLE_SLOTS; n++) queue_request(rrht_pkg::KIND_RELEASE, n, '0);

    fill_leaning = 1'b0;
    chunk_left = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      for (int n = 0; n < 160; n++) begin
        if (chunk_left == 0) begin
          fill_leaning = !fill_leaning;
          chunk_left = $urandom_range(90, 30);
        end
        pending_requests.push_back(random_request(fill_leaning));
        chunk_left--;
      end
      while (pending_requests.size() != 0) @(posedge clk);
    end

    // Drain: every request accepted, every response seen, then a quiet tail.
    while (pending_requests.size() != 0 || req_ch.valid) @(posedge clk);
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (TABLE_SLOTS + 8) @(posedge clk);

    $display("Checked %0d responses to %0d requests, %0d of them allocates.",
             responses_checked, requests_accepted, allocates_accepted);
    $display("Allocates that found the table full: %0d; mismatches: %0d.",
             full_responses, mismatch_count);
    if (mismatch_count == 0) begin
      $display("round_robin_handle_table_core test passed");
    end else begin
      $display("round_robin_handle_table_core test failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #15_000_000;
    $display("Timeout with %0d responses outstanding.", awaited_responses.size());
    $display("round_robin_handle_table_core test failed");
    $finish;
  end

endmodule

// ----- round_robin_handle_table_core.f -----
hdl/rrht_pkg.sv
hdl/rrht_req_if.sv
hdl/rrht_rsp_if.sv
hdl/rrht_ram.sv
hdl/round_robin_handle_table_core.sv
tb/sv/tb_round_robin_handle_table_core.sv
